// File: rtl/rmq_pkg.sv
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ---------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int DATA_W     = 16;
  localparam int TR_W       = DATA_W + 3;           // trace and radicand, signed
  localparam int RAD_W      = DATA_W + 1;           // positive radicand
  localparam int DIF_W      = DATA_W + 1;           // off-diagonal sum or difference
  localparam int SQ_IN_W    = 34;                   // radicand << (FRAC_BITS + 2), even
  localparam int SQ_STEPS   = SQ_IN_W / 2;          // one root bit per stage
  localparam int ROOT_W     = SQ_STEPS;             // floor(2*sqrt(x))
  localparam int SQ_REM_W   = ROOT_W + 1;
  localparam int DEN_W      = ROOT_W;               // 2*root
  localparam int NUM_W      = 32;                   // 2*mag*2^(FRAC_BITS-1) + root
  localparam int QUO_W      = 24;                   // quotient bits kept
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;
  localparam int SAT_LIM    = 65536;

  typedef enum logic [1:0] {
    PATH_TRACE = 2'd0,
    PATH_X     = 2'd1,
    PATH_Y     = 2'd2,
    PATH_Z     = 2'd3
  } path_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] qw;
    logic signed [DATA_W-1:0] qx;
    logic signed [DATA_W-1:0] qy;
    logic signed [DATA_W-1:0] qz;
    path_t                    path;
    logic                     invalid;
  } out_beat_t;

  // classified item handed from front to back
  typedef struct packed {
    path_t                   path;
    logic                    invalid;
    logic [RAD_W-1:0]        rad;
    logic signed [DIF_W-1:0] dw;
    logic signed [DIF_W-1:0] dx;
    logic signed [DIF_W-1:0] dy;
    logic signed [DIF_W-1:0] dz;
  } cls_t;

  // fifo to back handshake
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// File: rtl/rmq_front.sv
// ---------------------------------------------------------------------------
// rmq_front
// Takes matrix beats, picks the branch, forms the radicand and the
// off-diagonal terms, and holds the result in one register stage.
// ---------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output logic     cls_valid,
  input  logic     cls_ready,
  output cls_t     cls_data
);

  localparam logic signed [TR_W-1:0] ONE = TR_W'(1) <<< FRAC_BITS;

  logic                    front_v_r;
  cls_t                    front_r;
  cls_t                    cls_nxt;
  logic signed [TR_W-1:0]  trace;
  logic signed [TR_W-1:0]  rad;
  logic signed [DATA_W-1:0] big;
  path_t                   sel;

  function automatic logic signed [DIF_W-1:0] sx(input logic signed [DATA_W-1:0] v);
    return DIF_W'(v);
  endfunction

  function automatic logic signed [TR_W-1:0] tx(input logic signed [DATA_W-1:0] v);
    return TR_W'(v);
  endfunction

  // branch choice and terms
  always_comb begin
    trace = tx(in_data.m00) + tx(in_data.m11) + tx(in_data.m22);
    sel   = PATH_X;
    big   = in_data.m00;
    if (in_data.m11 > in_data.m00) begin
      sel = PATH_Y;
      big = in_data.m11;
    end
    if (in_data.m22 > big) begin
      sel = PATH_Z;
    end
    cls_nxt.dw = sx(in_data.m21) - sx(in_data.m12);
    cls_nxt.dx = sx(in_data.m21) - sx(in_data.m12);
    cls_nxt.dy = sx(in_data.m02) - sx(in_data.m20);
    cls_nxt.dz = sx(in_data.m10) - sx(in_data.m01);
    rad        = trace + ONE;
    if (trace > 0) begin
      cls_nxt.path = PATH_TRACE;
    end else begin
      cls_nxt.path = sel;
      case (sel)
        PATH_Y: begin
          rad = tx(in_data.m11) - tx(in_data.m22) - tx(in_data.m00) + ONE;
          cls_nxt.dw = sx(in_data.m02) - sx(in_data.m20);
          cls_nxt.dx = sx(in_data.m01) + sx(in_data.m10);
          cls_nxt.dz = sx(in_data.m21) + sx(in_data.m12);
        end
        PATH_Z: begin
          rad = tx(in_data.m22) - tx(in_data.m00) - tx(in_data.m11) + ONE;
          cls_nxt.dw = sx(in_data.m10) - sx(in_data.m01);
          cls_nxt.dx = sx(in_data.m02) + sx(in_data.m20);
          cls_nxt.dy = sx(in_data.m12) + sx(in_data.m21);
        end
        default: begin
          rad = tx(in_data.m00) - tx(in_data.m11) - tx(in_data.m22) + ONE;
          cls_nxt.dw = sx(in_data.m21) - sx(in_data.m12);
          cls_nxt.dy = sx(in_data.m10) + sx(in_data.m01);
          cls_nxt.dz = sx(in_data.m20) + sx(in_data.m02);
        end
      endcase
    end
    // non-positive radicand: run the datapath on one, zero the result later
    cls_nxt.invalid = (rad <= 0);
    cls_nxt.rad     = cls_nxt.invalid ? RAD_W'(1) : rad[RAD_W-1:0];
  end

  assign in_ready  = !front_v_r || cls_ready;
  assign cls_valid = front_v_r;
  assign cls_data  = front_r;

  // holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (in_ready) begin
      front_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      front_r <= cls_nxt;
    end
  end

endmodule

// File: rtl/rmq_fifo.sv
// ---------------------------------------------------------------------------
// rmq_fifo
// Short queue of classified items between front and back.
// ---------------------------------------------------------------------------
module rmq_fifo import rmq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cls_t push_data,
  output hs_t  pop_hs_o,
  input  logic pop_ready,
  output cls_t pop_data
);

  cls_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready     = (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_hs_o.valid = (cnt_r != '0);
  assign pop_hs_o.ready = pop_ready;
  assign pop_data       = mem_r[rd_ptr_r];
  assign do_push        = push_valid && push_ready;
  assign do_pop         = pop_hs_o.valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/rmq_div_lane.sv
// ---------------------------------------------------------------------------
// rmq_div_lane
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module rmq_div_lane import rmq_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] nb;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } dstage_t;

  dstage_t st_r  [QUO_W];
  dstage_t st_in [QUO_W];

  function automatic dstage_t div_step(input dstage_t s);
    dstage_t          o;
    logic [DEN_W:0]   t;
    logic             ge;
    t      = {s.rem, s.nb[QUO_W-1]};
    ge     = (t >= {1'b0, s.den});
    o.rem  = ge ? DEN_W'(t - {1'b0, s.den}) : t[DEN_W-1:0];
    o.nb   = {s.nb[QUO_W-2:0], 1'b0};
    o.quo  = {s.quo[QUO_W-2:0], ge};
    o.den  = s.den;
    return o;
  endfunction

  // the upper numerator bits are known to sit below the divisor
  always_comb begin
    st_in[0].rem = DEN_W'(num_i[NUM_W-1:QUO_W]);
    st_in[0].nb  = num_i[QUO_W-1:0];
    st_in[0].quo = '0;
    st_in[0].den = den_i;
    for (int s = 1; s < QUO_W; s++) begin
      st_in[s] = st_r[s-1];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QUO_W; s++) begin
        st_r[s] <= div_step(st_in[s]);
      end
    end
  end

  assign quo_o = st_r[QUO_W-1].quo;

endmodule

// File: rtl/rmq_back.sv
// ---------------------------------------------------------------------------
// rmq_back
// Square-root pipeline, four divider lanes, rounding, saturation and the
// output register.
// ---------------------------------------------------------------------------
module rmq_back import rmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  hs_t       q_hs_i,
  output logic      q_ready,
  input  cls_t      q_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [SQ_IN_W-1:0]  x;
    cls_t                cls;
  } sq_t;

  typedef struct packed {
    path_t             path;
    logic              invalid;
    logic [3:0]        neg;
    logic [DATA_W-1:0] half;
  } ctl_t;

  logic                en;
  logic                sq_v_r [SQ_STEPS];
  sq_t                 sq_r   [SQ_STEPS];
  sq_t                 sq_in  [SQ_STEPS];
  logic                pr_v_r;
  ctl_t                pr_ctl_r;
  logic [NUM_W-1:0]    pr_num_r [4];
  logic [DEN_W-1:0]    pr_den_r;
  logic                dv_v_r [QUO_W];
  ctl_t                dv_ctl_r [QUO_W];
  logic [QUO_W-1:0]    quo [4];
  logic [ROOT_W:0]     root_sum;
  logic [ROOT_W-1:0]   root;
  logic [ROOT_W-1:0]   half_sum;
  logic [NUM_W-1:0]    num_nxt [4];
  logic [3:0]          neg_nxt;
  logic signed [DIF_W-1:0] dd [4];
  logic signed [DATA_W-1:0] part [4];
  out_beat_t           out_r;
  logic                out_v_r;

  function automatic sq_t sq_step(input sq_t s);
    sq_t                 o;
    logic [SQ_REM_W+1:0] t;
    logic [ROOT_W+1:0]   trial;
    t     = {s.rem, s.x[SQ_IN_W-1 -: 2]};
    trial = {s.root, 2'b01};
    o     = s;
    if (t >= (SQ_REM_W+2)'(trial)) begin
      o.rem  = SQ_REM_W'(t - (SQ_REM_W+2)'(trial));
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = SQ_REM_W'(t);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.x = {s.x[SQ_IN_W-3:0], 2'b00};
    return o;
  endfunction

  // round-to-nearest quotient to a saturated signed part
  function automatic logic signed [DATA_W-1:0] finish(input logic [QUO_W-1:0] q,
                                                      input logic neg);
    logic [QUO_W-1:0] qc;
    qc = (q > QUO_W'(SAT_LIM)) ? QUO_W'(SAT_LIM) : q;
    if (!neg) begin
      return (qc > QUO_W'(32767)) ? DATA_W'(32767) : DATA_W'(qc);
    end
    return (qc >= QUO_W'(32768)) ? DATA_W'(32768) : DATA_W'(-qc);
  endfunction

  // whole pipeline moves while the output register can take a beat
  assign en      = !out_v_r || out_ready;
  assign q_ready = en;

  // square root of radicand << (FRAC_BITS + 2), two bits a stage
  always_comb begin
    sq_in[0].rem  = '0;
    sq_in[0].root = '0;
    sq_in[0].x    = SQ_IN_W'(q_data.rad) << (FRAC_BITS + 2);
    sq_in[0].cls  = q_data;
    for (int s = 1; s < SQ_STEPS; s++) begin
      sq_in[s] = sq_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SQ_STEPS; s++) begin
        sq_v_r[s] <= 1'b0;
      end
    end else if (en) begin
      sq_v_r[0] <= q_hs_i.valid;
      for (int s = 1; s < SQ_STEPS; s++) begin
        sq_v_r[s] <= sq_v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQ_STEPS; s++) begin
        sq_r[s] <= sq_step(sq_in[s]);
      end
    end
  end

  // root, half part and divider operands
  always_comb begin
    root_sum = {1'b0, sq_r[SQ_STEPS-1].root} + 1'b1;
    root     = root_sum[ROOT_W:1];
    half_sum = ROOT_W'(sq_r[SQ_STEPS-1].root[ROOT_W-1:1]) + 1'b1;
    dd[0]    = sq_r[SQ_STEPS-1].cls.dw;
    dd[1]    = sq_r[SQ_STEPS-1].cls.dx;
    dd[2]    = sq_r[SQ_STEPS-1].cls.dy;
    dd[3]    = sq_r[SQ_STEPS-1].cls.dz;
    for (int l = 0; l < 4; l++) begin
      neg_nxt[l] = dd[l][DIF_W-1];
      // magnitude is unsigned so the most negative sum keeps its full value
      num_nxt[l] = (NUM_W'($unsigned(neg_nxt[l] ? -dd[l] : dd[l])) << FRAC_BITS)
                   + NUM_W'(root);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
    end else if (en) begin
      pr_v_r <= sq_v_r[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_ctl_r.path    <= sq_r[SQ_STEPS-1].cls.path;
      pr_ctl_r.invalid <= sq_r[SQ_STEPS-1].cls.invalid;
      pr_ctl_r.neg     <= neg_nxt;
      pr_ctl_r.half    <= half_sum[ROOT_W-1] ? DATA_W'(32767)
                                             : DATA_W'(half_sum[ROOT_W-1:1]);
      pr_den_r         <= DEN_W'({root, 1'b0});
      for (int l = 0; l < 4; l++) begin
        pr_num_r[l] <= num_nxt[l];
      end
    end
  end

  // divider lanes for w, x, y, z
  for (genvar l = 0; l < 4; l++) begin : g_lane
    rmq_div_lane u_lane (
      .clk   (clk),
      .en    (en),
      .num_i (pr_num_r[l]),
      .den_i (pr_den_r),
      .quo_o (quo[l])
    );
  end

  // control riding beside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QUO_W; s++) begin
        dv_v_r[s] <= 1'b0;
      end
    end else if (en) begin
      dv_v_r[0] <= pr_v_r;
      for (int s = 1; s < QUO_W; s++) begin
        dv_v_r[s] <= dv_v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctl_r[0] <= pr_ctl_r;
      for (int s = 1; s < QUO_W; s++) begin
        dv_ctl_r[s] <= dv_ctl_r[s-1];
      end
    end
  end

  // pick half part or scaled part per slot
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (dv_ctl_r[QUO_W-1].invalid) begin
        part[l] = '0;
      end else if (dv_ctl_r[QUO_W-1].path == path_t'(l)) begin
        part[l] = dv_ctl_r[QUO_W-1].half;
      end else begin
        part[l] = finish(quo[l], dv_ctl_r[QUO_W-1].neg[l]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.qw      <= part[0];
      out_r.qx      <= part[1];
      out_r.qy      <= part[2];
      out_r.qz      <= part[3];
      out_r.path    <= dv_ctl_r[QUO_W-1].path;
      out_r.invalid <= dv_ctl_r[QUO_W-1].invalid;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: rtl/rotation_matrix_to_quaternion.sv
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Throughput: one beat per cycle unless the receiver stalls the result channel;
// the square root (17 stages) and the restoring dividers (24 stages, one
// quotient bit each) are fully pipelined.
// A four-entry queue sits between the classify stage and the arithmetic.
// Reset: synchronous active-low rst_n clears all valid state and the queue.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic cls_valid;
  logic cls_ready;
  cls_t cls_data;
  hs_t  q_hs;
  logic q_ready;
  cls_t q_data;

  // classify
  rmq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data)
  );

  // decoupling queue
  rmq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cls_valid),
    .push_ready (cls_ready),
    .push_data  (cls_data),
    .pop_hs_o   (q_hs),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // arithmetic
  rmq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_hs_i    (q_hs),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/rmq_checker.sv
// ---------------------------------------------------------------------------
// rmq_assert
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module rmq_assert import rmq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // invalid result is all zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |->
      out_data.qw == '0 && out_data.qx == '0 && out_data.qy == '0 && out_data.qz == '0)
    else $error("invalid result not zero");

  // positive trace never has a bad radicand
  a_trace: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.path == PATH_TRACE |-> !out_data.invalid)
    else $error("invalid flag on trace branch");

  // the half part on the chosen slot is never negative
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.invalid |->
      (out_data.path == PATH_TRACE && !out_data.qw[DATA_W-1]) ||
      (out_data.path == PATH_X && !out_data.qx[DATA_W-1]) ||
      (out_data.path == PATH_Y && !out_data.qy[DATA_W-1]) ||
      (out_data.path == PATH_Z && !out_data.qz[DATA_W-1]))
    else $error("negative half part");

endmodule

bind rotation_matrix_to_quaternion rmq_assert u_rmq_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/rmq_checker.sv
// ---------------------------------------------------------------------------
// rmq_checker
// Watches both channels of the rotation matrix to quaternion block, works out
// the quaternion for every accepted matrix beat and compares each result beat
// field by field against the oldest pending quaternion.
// ---------------------------------------------------------------------------
module rmq_checker import rmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_beat_t out_data,
  output int        fail_cnt,
  output int        pending_cnt
);

  out_beat_t quat_q[$];

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // round(d * 2^(FRAC_BITS-1) / root), ties away from zero
  function automatic logic signed [15:0] scale_diff(longint d, longint unsigned root);
    longint unsigned mag, num, q;
    longint v;
    mag = (d < 0) ? -d : d;
    num = mag << (FRAC_BITS - 1);
    q = (2 * num + root) / (2 * root);
    v = (q > 65536) ? 65536 : longint'(q);
    return clip16((d < 0) ? -v : v);
  endfunction

  function automatic out_beat_t quat_of(in_beat_t b);
    longint m[3][3];
    logic signed [15:0] q[4];
    longint trace, rad;
    longint unsigned x, half, root;
    int i, j, k;
    path_t p;
    out_beat_t r;
    m[0][0] = b.m00; m[0][1] = b.m01; m[0][2] = b.m02;
    m[1][0] = b.m10; m[1][1] = b.m11; m[1][2] = b.m12;
    m[2][0] = b.m20; m[2][1] = b.m21; m[2][2] = b.m22;
    trace = m[0][0] + m[1][1] + m[2][2];
    if (trace > 0) begin
      p = PATH_TRACE; i = 0; j = 1; k = 2;
      rad = trace + (64'sd1 << FRAC_BITS);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      p = path_t'(i + 1);
      rad = m[i][i] - m[j][j] - m[k][k] + (64'sd1 << FRAC_BITS);
    end
    r = '0;
    r.path = p;
    if (rad <= 0) begin
      r.invalid = 1'b1;
      return r;
    end
    x = longint'(rad) << FRAC_BITS;
    half = (int_sqrt(x) + 1) >> 1;
    root = (int_sqrt(x << 2) + 1) >> 1;
    q = '{default: '0};
    if (p == PATH_TRACE) begin
      q[0] = clip16((half > 65536) ? 65536 : longint'(half));
      q[1] = scale_diff(m[2][1] - m[1][2], root);
      q[2] = scale_diff(m[0][2] - m[2][0], root);
      q[3] = scale_diff(m[1][0] - m[0][1], root);
    end else begin
      q[1 + i] = clip16((half > 65536) ? 65536 : longint'(half));
      q[0] = scale_diff(m[k][j] - m[j][k], root);
      q[1 + j] = scale_diff(m[j][i] + m[i][j], root);
      q[1 + k] = scale_diff(m[k][i] + m[i][k], root);
    end
    r.qw = q[0]; r.qx = q[1]; r.qy = q[2]; r.qz = q[3];
    return r;
  endfunction

  assign pending_cnt = quat_q.size();

  // queue expected beats and compare results
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst_n) begin
      fail_cnt <= 0;
    end else begin
      if (in_valid && in_ready) quat_q.push_back(quat_of(in_data));
      if (out_valid && out_ready) begin
        if (quat_q.size() == 0) begin
          $error("result beat with nothing pending");
          fail_cnt <= fail_cnt + 1;
        end else begin
          e = quat_q.pop_front();
          if (e !== out_data) begin
            fail_cnt <= fail_cnt + 1;
            if (e.qw !== out_data.qw) $error("qw exp %0d got %0d", e.qw, out_data.qw);
            if (e.qx !== out_data.qx) $error("qx exp %0d got %0d", e.qx, out_data.qx);
            if (e.qy !== out_data.qy) $error("qy exp %0d got %0d", e.qy, out_data.qy);
            if (e.qz !== out_data.qz) $error("qz exp %0d got %0d", e.qz, out_data.qz);
            if (e.path !== out_data.path)
              $error("path exp %0d got %0d", e.path, out_data.path);
            if (e.invalid !== out_data.invalid)
              $error("invalid exp %0b got %0b", e.invalid, out_data.invalid);
          end
        end
      end
    end
  end

endmodule

// File: tb/rotation_matrix_to_quaternion_tb.sv
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives directed, then random matrices; random idling on both channels in
// two of three phases. The checker predicts and compares every quaternion.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int N_RAND    = 1450;
  localparam int WD_LIMIT  = 20000;
  localparam logic signed [15:0] ONE = 16'sd16384;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  int        fail_cnt, pending_cnt;
  int        send_idle = 0, recv_idle = 0;
  int        stall_cyc = 0;
  logic      done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rotation_matrix_to_quaternion dut (.*);

  rmq_checker chk (.*);

  // receiver stalls
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle);

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) stall_cyc <= 0;
    else stall_cyc <= stall_cyc + 1;
    if (stall_cyc >= WD_LIMIT) begin
      $display("rotation_matrix_to_quaternion regression: fail");
      $finish;
    end
  end

  // send one matrix beat, with random idle before it
  task automatic send_matrix(in_beat_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_elem();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      1: return 16'($signed($urandom_range(32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // near-rotation matrix, possibly with permuted and negated axes
  function automatic in_beat_t make_rot();
    in_beat_t b;
    logic signed [15:0] e[9];
    int perm, sgn;
    foreach (e[n]) e[n] = 16'($signed($urandom_range(400)) - 200);
    perm = $urandom_range(2);
    sgn = $urandom_range(3);
    for (int r = 0; r < 3; r++) begin
      int c;
      c = (r + perm) % 3;
      e[r * 3 + c] = ((sgn >> (r % 2)) & 1) ? -ONE + 16'($urandom_range(3000))
                                            : ONE - 16'($urandom_range(3000));
    end
    b = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return b;
  endfunction

  function automatic in_beat_t make_any();
    in_beat_t b;
    b = {rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
         rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
    return b;
  endfunction

  function automatic in_beat_t diag(logic signed [15:0] a, logic signed [15:0] b2,
                                    logic signed [15:0] c);
    in_beat_t b;
    b = '0;
    b.m00 = a; b.m11 = b2; b.m22 = c;
    b.m01 = 16'sd100; b.m10 = -16'sd50; b.m02 = 16'sd7; b.m21 = 16'sd300;
    return b;
  endfunction

  initial begin
    in_beat_t b;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity, each diagonal branch, ties, bad radicand, extremes
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix(diag(ONE, -ONE, -ONE));
    send_matrix(diag(-ONE, ONE, -ONE));
    send_matrix(diag(-ONE, -ONE, ONE));
    send_matrix(diag(0, 0, 0));
    send_matrix(diag(-16'sd100, -16'sd100, -16'sd100));
    send_matrix(diag(-16'sd5000, -16'sd5000, 16'sd200));
    send_matrix(diag(16'sd100, 16'sd32767, 16'sd32767));
    send_matrix(diag(-16'sd32768, -16'sd32768, -16'sd32768));
    send_matrix(diag(16'sd1, 16'sd0, -16'sd1));
    send_matrix({9{16'h7fff}});
    send_matrix({9{16'h8000}});
    b = diag(16'sd1, -16'sd32768, -16'sd32768);
    b.m01 = 16'h7fff; b.m10 = 16'h7fff; b.m02 = 16'h8000; b.m20 = 16'h8000;
    send_matrix(b);
    b = diag(-16'sd32768, 16'sd1, -16'sd32768);
    b.m12 = 16'h8000; b.m21 = 16'h7fff;
    send_matrix(b);
    b = diag(-16'sd32768, -16'sd32768, 16'sd32767);
    b.m01 = 16'h8000; b.m10 = 16'h7fff;
    send_matrix(b);
    b = diag(16'sd1, 16'sd0, 16'sd0);
    b.m21 = 16'h7fff; b.m12 = 16'h8000; b.m10 = 16'h7fff; b.m01 = 16'h8000;
    send_matrix(b);

    // hold off until the pipeline drains
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);

    // random, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 29 : (ph == 1) ? 73 : 0;
      recv_idle = (ph == 0) ? 73 : (ph == 1) ? 29 : 0;
      for (int n = 0; n < N_RAND / 3; n++)
        send_matrix(($urandom_range(99) < 70) ? make_rot() : make_any());
    end
    in_valid <= 1'b0;

    while (pending_cnt != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_cnt == 0) $display("rotation_matrix_to_quaternion regression: pass");
    else $display("rotation_matrix_to_quaternion regression: fail");
    $finish;
  end

endmodule
